FILE: sv/json_request_stream_parser_top_assert.svh
// assertion macros for the request parser checker
// expects i_clk and i_rst_n in the scope of use
`ifndef JSON_REQUEST_STREAM_PARSER_TOP_ASSERT_SVH
`define JSON_REQUEST_STREAM_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define JRSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JRSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jrsp_pkg.sv
// types and constants for the request stream parser
// used by the step logic, the top level, the checker and the testbench
package jrsp_pkg;

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_OBJ_OPEN    = 4'd1,
        PH_KEY_FIRST   = 4'd2,
        PH_KEY         = 4'd3,
        PH_COLON       = 4'd4,
        PH_VALUE       = 4'd5,
        PH_TYPE        = 4'd6,
        PH_PID         = 4'd7,
        PH_AFTER_VAL   = 4'd8,
        PH_AFTER_COMMA = 4'd9,
        PH_AFTER_CLOSE = 4'd10,
        PH_ERROR       = 4'd11
    } t_phase;

    typedef enum logic [3:0] {
        ERR_NONE        = 4'd0,
        ERR_EXP_STRING  = 4'd1,
        ERR_ESCAPE      = 4'd2,
        ERR_UNTERM_STR  = 4'd3,
        ERR_NOT_OBJECT  = 4'd4,
        ERR_EXP_COLON   = 4'd5,
        ERR_BAD_PID     = 4'd6,
        ERR_BAD_KEY     = 4'd7,
        ERR_TRAIL_COMMA = 4'd8,
        ERR_EXP_COMMA   = 4'd9,
        ERR_UNTERM_OBJ  = 4'd10,
        ERR_INVALID_REQ = 4'd11
    } t_err;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_TYPE_CHAR = 2'd1,
        EV_ACCEPT    = 2'd2,
        EV_REJECT    = 2'd3
    } t_event;

    // key prefix tracking
    localparam logic [2:0] KM_NONE = 3'd0;
    localparam logic [2:0] KM_T    = 3'd1;
    localparam logic [2:0] KM_TY   = 3'd2;
    localparam logic [2:0] KM_TYP  = 3'd3;
    localparam logic [2:0] KM_TYPE = 3'd4;
    localparam logic [2:0] KM_P    = 3'd5;
    localparam logic [2:0] KM_PI   = 3'd6;
    localparam logic [2:0] KM_PID  = 3'd7;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  key_match;
        logic        seen_type;
        logic        seen_pid;
        logic        type_nonempty;
        logic [31:0] pid_accum;
        logic        pid_digit_seen;
        t_err        first_error;
    } t_parse_state;

    localparam t_parse_state STATE_RESET = '{
        phase:          PH_START,
        key_match:      KM_NONE,
        seen_type:      1'b0,
        seen_pid:       1'b0,
        type_nonempty:  1'b0,
        pid_accum:      32'd0,
        pid_digit_seen: 1'b0,
        first_error:    ERR_NONE
    };

    typedef struct packed {
        t_event      event_res;
        logic [7:0]  type_char;
        logic [31:0] pid_value;
        logic        pid_present;
        t_err        error_code;
    } t_result;

endpackage

FILE: sv/jrsp_if.sv
// valid/ready channel interfaces for request bytes and result beats
// depends on nothing
interface jrsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport src (output valid, output byte_in, output last_byte, input ready);
    modport snk (input valid, input byte_in, input last_byte, output ready);
endinterface

interface jrsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [7:0]  type_char;
    logic [31:0] pid_value;
    logic        pid_present;
    logic [3:0]  error_code;

    modport src (output valid, output event_res, output type_char, output pid_value,
                 output pid_present, output error_code, input ready);
    modport snk (input valid, input event_res, input type_char, input pid_value,
                 input pid_present, input error_code, output ready);
endinterface

FILE: sv/jrsp_step.sv
// per-byte parser step: next parse state and result beat for one byte
// depends on jrsp_pkg
module jrsp_step
    import jrsp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_byte,
    input  logic         i_last,
    output t_parse_state o_state,
    output t_result      o_result
);

    function automatic logic [2:0] next_km(input logic [2:0] km, input logic first,
                                           input logic [7:0] c);
        logic [2:0] res;
        res = KM_NONE;
        if (first) begin
            if (c == "t") res = KM_T;
            else if (c == "p") res = KM_P;
        end else begin
            case (km)
                KM_T:    res = (c == "y") ? KM_TY   : KM_NONE;
                KM_TY:   res = (c == "p") ? KM_TYP  : KM_NONE;
                KM_TYP:  res = (c == "e") ? KM_TYPE : KM_NONE;
                KM_P:    res = (c == "i") ? KM_PI   : KM_NONE;
                KM_PI:   res = (c == "d") ? KM_PID  : KM_NONE;
                default: res = KM_NONE;
            endcase
        end
        return res;
    endfunction

    logic         is_ws;
    logic         is_dig;
    logic         is_esc;
    logic [35:0]  pid_x10;
    logic         pid_ovf;
    t_parse_state st;
    t_err         fcode;
    t_err         fin;
    t_err         err;
    logic         emit;

    assign is_ws  = (i_byte == CH_SPACE) || (i_byte == CH_TAB) ||
                    (i_byte == CH_CR) || (i_byte == CH_LF);
    assign is_dig = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_esc = (i_byte == CH_BSLASH) || (i_byte < CH_SPACE);

    // acc * 10 + digit as 8a + 2a + d
    assign pid_x10 = {1'b0, i_state.pid_accum, 3'b000}
                   + {3'b000, i_state.pid_accum, 1'b0}
                   + {32'd0, i_byte[3:0]};
    assign pid_ovf = (pid_x10[35:32] != 4'd0);

    always_comb begin
        st    = i_state;
        fcode = ERR_NONE;
        emit  = 1'b0;
        unique case (i_state.phase)
            PH_START: begin
                if (!is_ws) begin
                    if (i_byte == CH_LBRACE) st.phase = PH_OBJ_OPEN;
                    else fcode = ERR_NOT_OBJECT;
                end
            end
            PH_OBJ_OPEN, PH_AFTER_COMMA: begin
                if (!is_ws) begin
                    if (i_byte == CH_RBRACE) begin
                        if (i_state.phase == PH_AFTER_COMMA) fcode = ERR_TRAIL_COMMA;
                        else st.phase = PH_AFTER_CLOSE;
                    end else if (i_byte == CH_QUOTE) begin
                        st.phase = PH_KEY_FIRST;
                    end else begin
                        fcode = ERR_EXP_STRING;
                    end
                end
            end
            PH_KEY_FIRST, PH_KEY: begin
                if (i_byte == CH_QUOTE) begin
                    if (i_state.phase == PH_KEY_FIRST) st.key_match = KM_NONE;
                    st.phase = PH_COLON;
                end else if (is_esc) begin
                    fcode = ERR_ESCAPE;
                end else begin
                    st.key_match = next_km(i_state.key_match,
                                           i_state.phase == PH_KEY_FIRST, i_byte);
                    st.phase = PH_KEY;
                end
            end
            PH_COLON: begin
                if (!is_ws) begin
                    if (i_byte != CH_COLON) begin
                        fcode = ERR_EXP_COLON;
                    end else if ((i_state.key_match == KM_TYPE && !i_state.seen_type) ||
                                 (i_state.key_match == KM_PID && !i_state.seen_pid)) begin
                        st.phase = PH_VALUE;
                    end else begin
                        fcode = ERR_BAD_KEY;
                    end
                end
            end
            PH_VALUE: begin
                if (!is_ws) begin
                    if (i_state.key_match == KM_TYPE) begin
                        if (i_byte == CH_QUOTE) st.phase = PH_TYPE;
                        else fcode = ERR_EXP_STRING;
                    end else if (is_dig) begin
                        st.pid_accum      = {28'd0, i_byte[3:0]};
                        st.pid_digit_seen = 1'b1;
                        st.phase          = PH_PID;
                    end else begin
                        fcode = ERR_BAD_PID;
                    end
                end
            end
            PH_TYPE: begin
                if (i_byte == CH_QUOTE) begin
                    st.seen_type = 1'b1;
                    st.phase     = PH_AFTER_VAL;
                end else if (is_esc) begin
                    fcode = ERR_ESCAPE;
                end else begin
                    st.type_nonempty = 1'b1;
                    emit             = 1'b1;
                end
            end
            PH_PID: begin
                if (is_dig) begin
                    if (pid_ovf) fcode = ERR_BAD_PID;
                    else st.pid_accum = pid_x10[31:0];
                end else begin
                    st.seen_pid = 1'b1;
                    st.phase    = PH_AFTER_VAL;
                    if (!is_ws) begin
                        if (i_byte == CH_COMMA) st.phase = PH_AFTER_COMMA;
                        else if (i_byte == CH_RBRACE) st.phase = PH_AFTER_CLOSE;
                        else fcode = ERR_EXP_COMMA;
                    end
                end
            end
            PH_AFTER_VAL: begin
                if (!is_ws) begin
                    if (i_byte == CH_COMMA) st.phase = PH_AFTER_COMMA;
                    else if (i_byte == CH_RBRACE) st.phase = PH_AFTER_CLOSE;
                    else fcode = ERR_EXP_COMMA;
                end
            end
            PH_AFTER_CLOSE: begin
                if (!is_ws) fcode = ERR_INVALID_REQ;
            end
            default: begin
            end
        endcase

        if (fcode != ERR_NONE) begin
            if (i_state.first_error == ERR_NONE) st.first_error = fcode;
            st.phase = PH_ERROR;
        end

        // end-of-request check on the state left by this byte
        unique case (st.phase) inside
            PH_START:                    fin = ERR_NOT_OBJECT;
            PH_OBJ_OPEN, PH_AFTER_COMMA: fin = ERR_UNTERM_OBJ;
            PH_KEY_FIRST, PH_KEY, PH_TYPE: fin = ERR_UNTERM_STR;
            PH_COLON:                    fin = ERR_EXP_COLON;
            PH_VALUE:     fin = (st.key_match == KM_TYPE) ? ERR_EXP_STRING : ERR_BAD_PID;
            PH_PID:       fin = st.pid_digit_seen ? ERR_EXP_COMMA : ERR_BAD_PID;
            PH_AFTER_VAL:                fin = ERR_EXP_COMMA;
            PH_AFTER_CLOSE: fin = (!st.seen_type || !st.type_nonempty) ? ERR_INVALID_REQ
                                                                       : ERR_NONE;
            default:                     fin = ERR_NONE;
        endcase
        err = (st.first_error != ERR_NONE) ? st.first_error : fin;

        o_result = '{event_res: EV_NONE, type_char: 8'd0, pid_value: 32'd0,
                     pid_present: 1'b0, error_code: ERR_NONE};
        if (i_last) begin
            if (err == ERR_NONE) begin
                o_result.event_res = EV_ACCEPT;
                if (st.seen_pid) begin
                    o_result.pid_value   = st.pid_accum;
                    o_result.pid_present = 1'b1;
                end
            end else begin
                o_result.event_res  = EV_REJECT;
                o_result.error_code = err;
            end
            o_state = STATE_RESET;
        end else begin
            if (emit) begin
                o_result.event_res = EV_TYPE_CHAR;
                o_result.type_char = i_byte;
            end
            o_state = st;
        end
    end

endmodule

FILE: sv/json_request_stream_parser_top.sv
// channel    | dir | beat payload
// i_req      | in  | byte_in[7:0], last_byte
// o_res      | out | event_res[1:0], type_char[7:0], pid_value[31:0], pid_present,
//            |     | error_code[3:0]
// one result beat per request byte, one byte per cycle sustained while o_res is not stalled
// path: input register, then parser step into the result register
// the parse state is a single register updated by the step logic once per byte
// a stalled output holds its beat; the input register keeps taking bytes until it fills
// i_rst_n (synchronous) clears both valid bits and returns the parser to its start state
module json_request_stream_parser_top
    import jrsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    jrsp_in_if.snk i_req,
    jrsp_out_if.src o_res
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    t_result      r_res;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_res;
    logic         adv;

    assign adv         = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || adv;

    jrsp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_req.ready) r_in_valid <= i_req.valid;
            if (adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_in_byte <= i_req.byte_in;
            r_in_last <= i_req.last_byte;
        end
        if (adv && r_in_valid) r_res <= n_res;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_res   = r_res.event_res;
    assign o_res.type_char   = r_res.type_char;
    assign o_res.pid_value   = r_res.pid_value;
    assign o_res.pid_present = r_res.pid_present;
    assign o_res.error_code  = r_res.error_code;

endmodule

FILE: sv/jrsp_checker.sv
// port-level checks on the result channel of the request parser
// depends on jrsp_pkg and the assertion macro header; bound to the top level
`include "json_request_stream_parser_top_assert.svh"

module jrsp_checker
    import jrsp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_event_res,
    input logic [7:0]  i_type_char,
    input logic [31:0] i_pid_value,
    input logic        i_pid_present,
    input logic [3:0]  i_error_code
);

    logic [46:0] beat;
    logic        stalled;
    logic        is_char;
    logic        is_accept;
    logic        is_reject;
    logic        char_ok;
    logic        accept_ok;
    logic        reject_ok;

    assign beat      = {i_event_res, i_type_char, i_pid_value, i_pid_present, i_error_code};
    assign stalled   = i_valid && !i_ready;
    assign is_char   = i_valid && (i_event_res == EV_TYPE_CHAR);
    assign is_accept = i_valid && (i_event_res == EV_ACCEPT);
    assign is_reject = i_valid && (i_event_res == EV_REJECT);

    assign char_ok   = (i_type_char >= CH_SPACE) && (i_type_char != CH_QUOTE) &&
                       (i_type_char != CH_BSLASH) && (i_error_code == ERR_NONE) &&
                       !i_pid_present;
    assign accept_ok = (i_error_code == ERR_NONE) && (i_type_char == 8'd0) &&
                       (i_pid_present || (i_pid_value == 32'd0));
    assign reject_ok = (i_error_code != ERR_NONE) && (i_error_code <= ERR_INVALID_REQ) &&
                       !i_pid_present && (i_pid_value == 32'd0);

    `JRSP_ASSERT_NXT(a_stall_hold, stalled, i_valid && $stable(beat), "stalled beat changed")

    `JRSP_ASSERT_IMP(a_type_char, is_char, char_ok, "bad type character beat")

    `JRSP_ASSERT_IMP(a_accept, is_accept, accept_ok, "bad accept beat")

    `JRSP_ASSERT_IMP(a_reject, is_reject, reject_ok, "bad reject beat")

endmodule

bind json_request_stream_parser_top jrsp_checker u_jrsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_res.valid),
    .i_ready       (o_res.ready),
    .i_event_res   (o_res.event_res),
    .i_type_char   (o_res.type_char),
    .i_pid_value   (o_res.pid_value),
    .i_pid_present (o_res.pid_present),
    .i_error_code  (o_res.error_code)
);

FILE: tb/tb_json_request_stream_parser_top.sv
`timescale 1ns / 1ps
// self-checking testbench for json_request_stream_parser_top: drives request bytes,
// predicts every result beat with an in-bench parser and compares field by field
// depends on jrsp_pkg, jrsp_if.sv and the top level
module tb_json_request_stream_parser_top;
    import jrsp_pkg::*;

    typedef enum int {
        MUT_NONE, MUT_FLIP, MUT_CUT, MUT_INSERT, MUT_TRAIL_DATA, MUT_DUP_KEY,
        MUT_ODD_KEY, MUT_TRAIL_COMMA, MUT_CTRL_CHAR, MUT_NO_TYPE
    } t_mutation;

    typedef enum int {FLD_TYPE, FLD_PID, FLD_ODD} t_field;

    localparam int unsigned HOLD_CYCLES = 150;

    logic i_clk;
    logic i_rst_n;

    jrsp_in_if  req_if ();
    jrsp_out_if res_if ();

    json_request_stream_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // shadow of the parse state
    t_phase      sh_phase;
    logic [2:0]  sh_key;
    logic        sh_seen_type;
    logic        sh_seen_pid;
    logic        sh_type_nonempty;
    logic        sh_pid_digit;
    logic [31:0] sh_pid;
    t_err        sh_err;

    t_result     pending_results[$];
    logic [7:0]  req_text[$];
    int unsigned mismatch_count;
    int unsigned bytes_sent;
    bit          src_gaps_on;
    bit          snk_gaps_on;
    bit          hold_req;

    string odd_keys [0:7] = '{"typ", "pidx", "tYpe", "p", "", "types", "id", "pi"};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[json_request_stream_parser_top] ERROR");
        $finish;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void clear_parse();
        sh_phase         = PH_START;
        sh_key           = KM_NONE;
        sh_seen_type     = 1'b0;
        sh_seen_pid      = 1'b0;
        sh_type_nonempty = 1'b0;
        sh_pid_digit     = 1'b0;
        sh_pid           = 32'd0;
        sh_err           = ERR_NONE;
    endfunction

    function automatic void take_error(t_err e);
        if (sh_err == ERR_NONE) sh_err = e;
        sh_phase = PH_ERROR;
    endfunction

    function automatic void after_value(logic [7:0] c);
        if (is_blank(c)) return;
        if (c == CH_COMMA) sh_phase = PH_AFTER_COMMA;
        else if (c == CH_RBRACE) sh_phase = PH_AFTER_CLOSE;
        else take_error(ERR_EXP_COMMA);
    endfunction

    function automatic logic [2:0] key_step(logic [2:0] km, bit first, logic [7:0] c);
        if (first) begin
            if (c == "t") return KM_T;
            if (c == "p") return KM_P;
            return KM_NONE;
        end
        case (km)
            KM_T:    return (c == "y") ? KM_TY : KM_NONE;
            KM_TY:   return (c == "p") ? KM_TYP : KM_NONE;
            KM_TYP:  return (c == "e") ? KM_TYPE : KM_NONE;
            KM_P:    return (c == "i") ? KM_PI : KM_NONE;
            KM_PI:   return (c == "d") ? KM_PID : KM_NONE;
            default: return KM_NONE;
        endcase
    endfunction

    // returns 1 when the byte is a type character to pass out
    function automatic bit consume_byte(logic [7:0] c);
        logic [35:0] wide;
        case (sh_phase)
            PH_START: begin
                if (!is_blank(c)) begin
                    if (c == CH_LBRACE) sh_phase = PH_OBJ_OPEN;
                    else take_error(ERR_NOT_OBJECT);
                end
            end
            PH_OBJ_OPEN, PH_AFTER_COMMA: begin
                if (!is_blank(c)) begin
                    if (c == CH_RBRACE) begin
                        if (sh_phase == PH_AFTER_COMMA) take_error(ERR_TRAIL_COMMA);
                        else sh_phase = PH_AFTER_CLOSE;
                    end else if (c == CH_QUOTE) begin
                        sh_phase = PH_KEY_FIRST;
                    end else begin
                        take_error(ERR_EXP_STRING);
                    end
                end
            end
            PH_KEY_FIRST, PH_KEY: begin
                if (c == CH_QUOTE) begin
                    if (sh_phase == PH_KEY_FIRST) sh_key = KM_NONE;
                    sh_phase = PH_COLON;
                end else if (c == CH_BSLASH || c < CH_SPACE) begin
                    take_error(ERR_ESCAPE);
                end else begin
                    sh_key   = key_step(sh_key, sh_phase == PH_KEY_FIRST, c);
                    sh_phase = PH_KEY;
                end
            end
            PH_COLON: begin
                if (!is_blank(c)) begin
                    if (c != CH_COLON) begin
                        take_error(ERR_EXP_COLON);
                    end else if ((sh_key == KM_TYPE && !sh_seen_type) ||
                                 (sh_key == KM_PID && !sh_seen_pid)) begin
                        sh_phase = PH_VALUE;
                    end else begin
                        take_error(ERR_BAD_KEY);
                    end
                end
            end
            PH_VALUE: begin
                if (!is_blank(c)) begin
                    if (sh_key == KM_TYPE) begin
                        if (c == CH_QUOTE) sh_phase = PH_TYPE;
                        else take_error(ERR_EXP_STRING);
                    end else if (is_digit(c)) begin
                        sh_pid       = 32'(c - CH_ZERO);
                        sh_pid_digit = 1'b1;
                        sh_phase     = PH_PID;
                    end else begin
                        take_error(ERR_BAD_PID);
                    end
                end
            end
            PH_TYPE: begin
                if (c == CH_QUOTE) begin
                    sh_seen_type = 1'b1;
                    sh_phase     = PH_AFTER_VAL;
                end else if (c == CH_BSLASH || c < CH_SPACE) begin
                    take_error(ERR_ESCAPE);
                end else begin
                    sh_type_nonempty = 1'b1;
                    return 1'b1;
                end
            end
            PH_PID: begin
                if (is_digit(c)) begin
                    wide = {4'd0, sh_pid} * 36'd10 + 36'(c - CH_ZERO);
                    if (wide > 36'hFFFF_FFFF) take_error(ERR_BAD_PID);
                    else sh_pid = wide[31:0];
                end else begin
                    sh_seen_pid = 1'b1;
                    sh_phase    = PH_AFTER_VAL;
                    after_value(c);
                end
            end
            PH_AFTER_VAL: after_value(c);
            PH_AFTER_CLOSE: begin
                if (!is_blank(c)) take_error(ERR_INVALID_REQ);
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void close_request();
        case (sh_phase)
            PH_START:                    take_error(ERR_NOT_OBJECT);
            PH_OBJ_OPEN, PH_AFTER_COMMA: take_error(ERR_UNTERM_OBJ);
            PH_KEY_FIRST, PH_KEY, PH_TYPE: take_error(ERR_UNTERM_STR);
            PH_COLON:                    take_error(ERR_EXP_COLON);
            PH_VALUE: begin
                if (sh_key == KM_TYPE) take_error(ERR_EXP_STRING);
                else take_error(ERR_BAD_PID);
            end
            PH_PID: begin
                if (sh_pid_digit) take_error(ERR_EXP_COMMA);
                else take_error(ERR_BAD_PID);
            end
            PH_AFTER_VAL: take_error(ERR_EXP_COMMA);
            PH_AFTER_CLOSE: begin
                if (!sh_seen_type || !sh_type_nonempty) take_error(ERR_INVALID_REQ);
            end
            default: ;
        endcase
    endfunction

    function automatic t_result result_for_byte(logic [7:0] c, logic last);
        t_result r;
        bit      emit;
        emit          = consume_byte(c);
        r.event_res   = EV_NONE;
        r.type_char   = 8'd0;
        r.pid_value   = 32'd0;
        r.pid_present = 1'b0;
        r.error_code  = ERR_NONE;
        if (last) begin
            close_request();
            if (sh_err == ERR_NONE) begin
                r.event_res = EV_ACCEPT;
                if (sh_seen_pid) begin
                    r.pid_value   = sh_pid;
                    r.pid_present = 1'b1;
                end
            end else begin
                r.event_res  = EV_REJECT;
                r.error_code = sh_err;
            end
            clear_parse();
        end else if (emit) begin
            r.event_res = EV_TYPE_CHAR;
            r.type_char = c;
        end
        return r;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : res_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: beat with nothing expected, expected none, actual event %0d",
                         $time, res_if.event_res);
            end else begin
                want = pending_results.pop_front();
                check_field("event_res", want.event_res, res_if.event_res);
                check_field("type_char", want.type_char, res_if.type_char);
                check_field("pid_value", want.pid_value, res_if.pid_value);
                check_field("pid_present", want.pid_present, res_if.pid_present);
                check_field("error_code", want.error_code, res_if.error_code);
            end
        end
    end

    // result side ready, with random stalls and the long hold-off on request
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (snk_gaps_on && $urandom_range(0, 99) < 25) begin
                res_if.ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_byte(logic [7:0] c, logic last);
        int unsigned n;
        req_if.valid     <= 1'b1;
        req_if.byte_in   <= c;
        req_if.last_byte <= last;
        do @(posedge i_clk); while (!req_if.ready);
        pending_results.insert(pending_results.size(), result_for_byte(c, last));
        bytes_sent++;
        if (src_gaps_on) begin
            n = gap_len();
            if (n > 0) begin
                req_if.valid <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_request();
        foreach (req_text[i]) send_byte(req_text[i], i == req_text.size() - 1);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic add_str(string s);
        for (int i = 0; i < s.len(); i++) req_text.insert(req_text.size(), s[i]);
    endtask

    task automatic add_blank();
        logic [7:0] blanks [0:3];
        blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
        if ($urandom_range(0, 99) < 70) return;
        repeat ($urandom_range(1, 2)) begin
            req_text.insert(req_text.size(), blanks[$urandom_range(0, 3)]);
        end
    endtask

    task automatic add_key(string k);
        add_str({"\"", k, "\""});
        add_blank();
        add_str(":");
        add_blank();
    endtask

    task automatic add_type_value(bit bad);
        int unsigned n;
        int unsigned bad_at;
        logic [7:0]  c;
        n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        if (bad && n == 0) n = 1;
        bad_at = bad ? $urandom_range(0, n - 1) : 0;
        add_str("\"");
        for (int i = 0; i < n; i++) begin
            do c = 8'($urandom_range(32, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            if (bad && i == bad_at) begin
                c = $urandom_range(0, 1) ? CH_BSLASH : 8'($urandom_range(0, 31));
            end
            req_text.insert(req_text.size(), c);
        end
        add_str("\"");
    endtask

    task automatic add_pid_value();
        longint unsigned v;
        int unsigned     r;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_str("0");
        if (r < 40) v = $urandom_range(0, 999);
        else if (r < 75) v = $urandom();
        else if (r < 85) v = 64'hFFFF_FFFF;
        else if (r < 95) v = 64'h1_0000_0000 + $urandom_range(0, 9);
        else v = {$urandom(), $urandom()} % 64'd100_000_000_000;
        add_str($sformatf("%0d", v));
    endtask

    // builds one request, well formed unless a mutation is picked
    task automatic build_request(bit clean);
        t_mutation   how;
        t_field      fields[$];
        int unsigned pos;
        req_text.delete();
        if (clean || $urandom_range(0, 99) < 55) how = MUT_NONE;
        else how = t_mutation'($urandom_range(int'(MUT_FLIP), int'(MUT_NO_TYPE)));
        if (how != MUT_NO_TYPE) fields.insert(fields.size(), FLD_TYPE);
        if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) fields.push_front(FLD_PID);
            else fields.insert(fields.size(), FLD_PID);
        end
        if (how == MUT_DUP_KEY) begin
            fields.insert($urandom_range(0, fields.size()),
                          fields[$urandom_range(0, fields.size() - 1)]);
        end
        if (how == MUT_ODD_KEY) fields.insert($urandom_range(0, fields.size()), FLD_ODD);

        add_blank();
        add_str("{");
        add_blank();
        foreach (fields[i]) begin
            if (i > 0) begin
                add_str(",");
                add_blank();
            end
            case (fields[i])
                FLD_TYPE: begin
                    add_key("type");
                    add_type_value(how == MUT_CTRL_CHAR);
                end
                FLD_PID: begin
                    add_key("pid");
                    add_pid_value();
                end
                default: begin
                    add_key(odd_keys[$urandom_range(0, 7)]);
                    add_str("7");
                end
            endcase
            add_blank();
        end
        if (how == MUT_TRAIL_COMMA) add_str(",");
        add_str("}");
        add_blank();
        if (how == MUT_TRAIL_DATA) add_str("x");

        pos = $urandom_range(0, req_text.size() - 1);
        case (how)
            MUT_FLIP:   req_text[pos] = 8'($urandom_range(0, 255));
            MUT_CUT:    req_text = req_text[0:pos];
            MUT_INSERT: req_text.insert(pos, 8'($urandom_range(0, 255)));
            default: ;
        endcase
    endtask

    task automatic test_directed_cases();
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        send_text("{\"type\":\"x\"}");
        send_text("{\"type\":\"ab\",\"pid\":4294967295}");
        send_text(" \t\015\n{ \"pid\" : 0007 ,\n\"type\" : \" \377\200~\" } \n");
        send_text("{\"pid\":4294967296}");
        send_text("{\"pid\":x}");
        send_byte(8'h00, 1'b1);
        send_text("{");
        send_text("{5}");
        send_text("{\"ty\\pe\":\"a\"}");
        send_text("{\"type\":\"a\001\"}");
        send_text("{\"typ");
        send_text("{\"type\":\"ab");
        send_text("{\"type\" x}");
        send_text("{\"type\"");
        send_text("{\"foo\":1}");
        send_text("{\"type\":\"a\",\"type\":\"b\"}");
        send_text("{\"type\":\"a\",}");
        send_text("{\"type\":\"a\" \"pid\":1}");
        send_text("{\"pid\":12");
        send_text("{\"pid\":");
        send_text("{\"type\":");
        send_text("{\"type\":\"a\",");
        send_text("{\"type\":\"a\"}x");
        send_text("{\"type\":\"\"}");
        send_text("{}");
        send_text("{\"pid\":1}");
        send_text("{\"type\":5}");
        wait_drained();
    endtask

    task automatic test_random_requests(int unsigned n_bytes);
        int unsigned stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            src_gaps_on = ($urandom_range(0, 3) != 0);
            snk_gaps_on = ($urandom_range(0, 3) != 0);
            build_request(1'b0);
            send_request();
        end
        wait_drained();
    endtask

    // long result stall while bytes keep coming, so the input side backs up
    task automatic test_output_hold();
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        hold_req    = 1'b1;
        repeat (4) begin
            build_request(1'b1);
            send_request();
        end
        wait_drained();
    endtask

    task automatic test_unbroken_stream(int unsigned n_bytes);
        int unsigned stop_at;
        src_gaps_on = 1'b0;
        snk_gaps_on = 1'b0;
        stop_at     = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            build_request(1'b0);
            send_request();
        end
        wait_drained();
    endtask

    task automatic test_noise();
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
        repeat (30) begin
            req_text.delete();
            if ($urandom_range(0, 1)) add_str("{");
            repeat ($urandom_range(1, 6)) begin
                req_text.insert(req_text.size(), 8'($urandom_range(0, 255)));
            end
            send_request();
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.byte_in   <= 8'd0;
        req_if.last_byte <= 1'b0;
        mismatch_count = 0;
        bytes_sent     = 0;
        src_gaps_on    = 1'b0;
        snk_gaps_on    = 1'b0;
        hold_req       = 1'b0;
        clear_parse();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_random_requests(220);
        test_output_hold();
        test_unbroken_stream(120);
        test_noise();
        test_random_requests(80);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("[json_request_stream_parser_top] OK");
        end else begin
            $display("[json_request_stream_parser_top] ERROR");
        end
        $finish;
    end

endmodule
